### src/brs_pkg.sv
package brs_pkg;

    // Default geometry, overridable at the top level.
    localparam int PAGE_SHIFT_DEF        = 12;
    localparam int SEGMENTS_PER_SLOT_DEF = 11;

    // A disk block is 512 bytes.
    localparam int BLK_SHIFT = 9;

    // Operation codes of an input word.
    localparam logic OP_START = 1'b0;
    localparam logic OP_PAGE  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_SLOT    = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_STARTED   = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_UNALIGNED = 3'd2;
    localparam logic [2:0] ST_BAD_BLOCK = 3'd3;
    localparam logic [2:0] ST_NO_XFER   = 3'd4;

    // Configuration register indexes.
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_DEVICE   = 1'b1;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [31:0] segment_word;
        logic [31:0] sector;
        logic [3:0]  segment_count;
        logic        write_op;
        logic [15:0] device;
        logic        last;
    } result_t;

endpackage

### src/brs_core.sv
module brs_core #(
    parameter int PAGE_SHIFT        = brs_pkg::PAGE_SHIFT_DEF,
    parameter int SEGMENTS_PER_SLOT = brs_pkg::SEGMENTS_PER_SLOT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              operation,
    input  logic [31:0]       start_block,
    input  logic [31:0]       byte_count,
    input  logic [11:0]       byte_offset,
    input  logic              write_flag,
    input  logic [19:0]       machine_page,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    output brs_pkg::result_t  res0,
    output brs_pkg::result_t  res1,
    output logic              two
);

    localparam int ROOM_W = PAGE_SHIFT + 1;
    localparam int BLK_W  = ROOM_W - brs_pkg::BLK_SHIFT;
    localparam logic [ROOM_W-1:0] PAGE_BYTES = {1'b1, {PAGE_SHIFT{1'b0}}};
    localparam logic [11:0] OFFS_MASK =
        (PAGE_SHIFT >= 12) ? 12'hFFF : 12'((32'd1 << PAGE_SHIFT) - 32'd1);
    localparam logic [3:0] SEG_LIMIT = 4'(SEGMENTS_PER_SLOT);

    logic [31:0] capacity_reg;
    logic [15:0] device_reg;

    logic [31:0] remaining_reg, remaining_next;
    logic [11:0] page_offset_reg, page_offset_next;
    logic [31:0] next_sector_reg, next_sector_next;
    logic [31:0] slot_sector_reg, slot_sector_next;
    logic [3:0]  slot_segments_reg, slot_segments_next;
    logic        write_mode_reg, write_mode_next;
    logic        active_reg, active_next;

    logic [32:0]              end_sum;
    logic [2:0]               start_status;
    logic [ROOM_W-1:0]        room;
    logic [ROOM_W-1:0]        bytes;
    logic [BLK_W-1:0]         blocks;
    logic [31:0]              rem_after;
    logic [31:0]              sector_after;
    logic [3:0]               seg_after;
    logic                     close;
    logic [PAGE_SHIFT+19:0]   page_wide;
    logic [31:0]              word;

    // Start check: empty first, then alignment, then the end block range.
    assign end_sum = {1'b0, start_block} + 33'(byte_count[31:brs_pkg::BLK_SHIFT]);

    always_comb
    begin
        if (byte_count == '0)
        begin
            start_status = brs_pkg::ST_EMPTY;
        end
        else if ((byte_count[brs_pkg::BLK_SHIFT-1:0]
                  | byte_offset[brs_pkg::BLK_SHIFT-1:0]) != '0)
        begin
            start_status = brs_pkg::ST_UNALIGNED;
        end
        else if (end_sum[32] || (end_sum[31:0] > capacity_reg))
        begin
            start_status = brs_pkg::ST_BAD_BLOCK;
        end
        else
        begin
            start_status = brs_pkg::ST_STARTED;
        end
    end

    // Segment length: the rest of the page or the rest of the transfer.
    // At most one page of blocks, so the 512-block cap never applies.
    assign room         = PAGE_BYTES - ROOM_W'(page_offset_reg);
    assign bytes        = (32'(room) < remaining_reg) ? room : remaining_reg[ROOM_W-1:0];
    assign blocks       = bytes[ROOM_W-1:brs_pkg::BLK_SHIFT];
    assign rem_after    = remaining_reg - 32'({blocks, {brs_pkg::BLK_SHIFT{1'b0}}});
    assign sector_after = next_sector_reg + 32'(blocks);
    assign seg_after    = slot_segments_reg + 4'd1;
    assign close        = (seg_after >= SEG_LIMIT) || (rem_after == '0);
    assign page_wide    = {machine_page, {PAGE_SHIFT{1'b0}}};
    assign word         = 32'(page_wide) | 32'(page_offset_reg) | 32'(blocks);

    // Results and next state for the word on the input ports.
    always_comb
    begin
        res0               = '0;
        res1               = '0;
        two                = 1'b0;
        res0.last          = 1'b1;
        remaining_next     = remaining_reg;
        page_offset_next   = page_offset_reg;
        next_sector_next   = next_sector_reg;
        slot_sector_next   = slot_sector_reg;
        slot_segments_next = slot_segments_reg;
        write_mode_next    = write_mode_reg;
        active_next        = active_reg;

        if (operation == brs_pkg::OP_START)
        begin
            res0.kind   = brs_pkg::KIND_STATUS;
            res0.status = start_status;
            active_next = 1'b0;
            if (start_status == brs_pkg::ST_STARTED)
            begin
                remaining_next     = byte_count;
                page_offset_next   = byte_offset & OFFS_MASK;
                next_sector_next   = start_block;
                slot_sector_next   = start_block;
                slot_segments_next = '0;
                write_mode_next    = write_flag;
                active_next        = 1'b1;
            end
        end
        else if (!active_reg)
        begin
            res0.kind   = brs_pkg::KIND_STATUS;
            res0.status = brs_pkg::ST_NO_XFER;
        end
        else
        begin
            res0.kind          = brs_pkg::KIND_SEGMENT;
            res0.segment_word  = word;
            res0.last          = !close;
            remaining_next     = rem_after;
            next_sector_next   = sector_after;
            page_offset_next   = '0;
            slot_segments_next = seg_after;
            if (close)
            begin
                two                = 1'b1;
                res1.kind          = brs_pkg::KIND_SLOT;
                res1.sector        = slot_sector_reg;
                res1.segment_count = seg_after;
                res1.write_op      = write_mode_reg;
                res1.device        = device_reg;
                res1.last          = 1'b1;
                slot_sector_next   = sector_after;
                slot_segments_next = '0;
                if (rem_after == '0)
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    // Transfer state, updated on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg     <= '0;
            page_offset_reg   <= '0;
            next_sector_reg   <= '0;
            slot_sector_reg   <= '0;
            slot_segments_reg <= '0;
            write_mode_reg    <= 1'b0;
            active_reg        <= 1'b0;
        end
        else if (accept)
        begin
            remaining_reg     <= remaining_next;
            page_offset_reg   <= page_offset_next;
            next_sector_reg   <= next_sector_next;
            slot_sector_reg   <= slot_sector_next;
            slot_segments_reg <= slot_segments_next;
            write_mode_reg    <= write_mode_next;
            active_reg        <= active_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
            device_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                brs_pkg::REG_CAPACITY: capacity_reg <= cfg_data;
                brs_pkg::REG_DEVICE:   device_reg   <= cfg_data[15:0];
                default:               ;
            endcase
        end
    end

endmodule

### src/brs_out_buf.sv
module brs_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              two,
    input  brs_pkg::result_t  res0,
    input  brs_pkg::result_t  res1,
    input  logic              out_stall,
    output logic              space,
    output logic              out_valid,
    output brs_pkg::result_t  head
);

    logic              head_valid_reg;
    logic              spill_valid_reg;
    brs_pkg::result_t  head_reg;
    brs_pkg::result_t  spill_reg;
    logic              pop;

    // Room for both results of the next word.
    assign pop       = head_valid_reg && !out_stall;
    assign space     = !spill_valid_reg && (!head_valid_reg || !out_stall);
    assign out_valid = head_valid_reg;
    assign head      = head_reg;

    // Occupancy of the output register and its spill stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spill_valid_reg <= 1'b0;
        end
        else if (spill_valid_reg)
        begin
            if (pop)
            begin
                spill_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            head_valid_reg  <= 1'b1;
            spill_valid_reg <= two;
        end
        else if (pop)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (spill_valid_reg)
        begin
            if (pop)
            begin
                head_reg <= spill_reg;
            end
        end
        else if (push)
        begin
            head_reg  <= res0;
            spill_reg <= res1;
        end
    end

`ifndef ASSERT_OFF
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !spill_valid_reg)
        else $error("word accepted while the spill stage is full");

    a_spill_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        spill_valid_reg |-> head_valid_reg)
        else $error("spill stage holds a word with no word in front of it");

    a_two_fills_spill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && two) |=> spill_valid_reg)
        else $error("second result of a word was dropped");

    a_spill_is_slot: assert property (@(posedge clk) disable iff (!rst_n)
        spill_valid_reg |-> (spill_reg.kind == brs_pkg::KIND_SLOT))
        else $error("spill stage holds something other than a slot record");
`endif

endmodule

### src/block_request_segmenter_unit.sv
// A result appears on the output in the cycle after its input word is accepted.
// A slot record waits in the spill stage until its segment word leaves the output.
// Throughput: one word per cycle unless the output stalls; a slot-closing page word
// stalls the next word, as both its results leave through the single output register.
// Reset (rst_n, asynchronous): no transfer active, control registers zero, output empty.
module block_request_segmenter_unit #(
    parameter int PAGE_SHIFT        = brs_pkg::PAGE_SHIFT_DEF,
    parameter int SEGMENTS_PER_SLOT = brs_pkg::SEGMENTS_PER_SLOT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] start_block,
    input  logic [31:0] byte_count,
    input  logic [11:0] byte_offset,
    input  logic        write_flag,
    input  logic [19:0] machine_page,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [2:0]  status,
    output logic [31:0] segment_word,
    output logic [31:0] sector,
    output logic [3:0]  segment_count,
    output logic        write_op,
    output logic [15:0] device,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    brs_pkg::result_t res0;
    brs_pkg::result_t res1;
    brs_pkg::result_t head;
    logic             two;
    logic             space;
    logic             accept;

    // A word is taken whenever the output side can hold both of its results.
    assign in_stall  = !space;
    assign accept    = in_valid && space;
    assign cfg_ready = 1'b1;

    brs_core #(
        .PAGE_SHIFT        (PAGE_SHIFT),
        .SEGMENTS_PER_SLOT (SEGMENTS_PER_SLOT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .start_block  (start_block),
        .byte_count   (byte_count),
        .byte_offset  (byte_offset),
        .write_flag   (write_flag),
        .machine_page (machine_page),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .res0         (res0),
        .res1         (res1),
        .two          (two)
    );

    brs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .two       (two),
        .res0      (res0),
        .res1      (res1),
        .out_stall (out_stall),
        .space     (space),
        .out_valid (out_valid),
        .head      (head)
    );

    // Output fields.
    assign kind          = head.kind;
    assign status        = head.status;
    assign segment_word  = head.segment_word;
    assign sector        = head.sector;
    assign segment_count = head.segment_count;
    assign write_op      = head.write_op;
    assign device        = head.device;
    assign last          = head.last;

endmodule

### bench/tb.sv
module tb;

    localparam int PAGE_SHIFT        = brs_pkg::PAGE_SHIFT_DEF;
    localparam int SEGMENTS_PER_SLOT = brs_pkg::SEGMENTS_PER_SLOT_DEF;
    localparam int ITEM_TARGET       = 550;
    localparam int LIMIT_CYCLES      = 200000;
    localparam int HOLD_CYCLES       = 250;

    // Tracks the expected descriptor stream of the segmenter and checks the
    // words that leave it.
    class descriptor_tracker;
        brs_pkg::result_t due_results[$];
        int unsigned      mismatches;
        logic [31:0]      capacity;
        logic [15:0]      device_no;
        logic [31:0]      bytes_left;
        logic [11:0]      page_pos;
        logic [31:0]      next_blk;
        logic [31:0]      slot_blk;
        logic [3:0]       slot_segs;
        logic             dir_write;
        logic             busy;

        function new();
            mismatches = 0;
            capacity   = '0;
            device_no  = '0;
            bytes_left = '0;
            page_pos   = '0;
            next_blk   = '0;
            slot_blk   = '0;
            slot_segs  = '0;
            dir_write  = 1'b0;
            busy       = 1'b0;
        endfunction

        function void set_register(logic idx, logic [31:0] data);
            if (idx == brs_pkg::REG_CAPACITY)
                capacity = data;
            else
                device_no = data[15:0];
        endfunction

        function brs_pkg::result_t status_word(logic [2:0] code);
            brs_pkg::result_t r;
            r        = '0;
            r.kind   = brs_pkg::KIND_STATUS;
            r.status = code;
            r.last   = 1'b1;
            return r;
        endfunction

        // Works out the results that one accepted input word causes.
        function void take_word(logic op, logic [31:0] sblk, logic [31:0] cnt,
                                logic [11:0] offs, logic wr, logic [19:0] page);
            brs_pkg::result_t r;
            logic [32:0]      end_blk;
            logic [32:0]      page_bytes;
            logic [32:0]      masked;
            logic [32:0]      room;
            logic [32:0]      take;
            logic [31:0]      blocks;
            logic [63:0]      wide;
            logic [2:0]       code;
            logic             close;

            page_bytes = 33'd1 << PAGE_SHIFT;
            if (op == brs_pkg::OP_START)
            begin
                // A start abandons any transfer in progress, then is checked.
                busy    = 1'b0;
                end_blk = {1'b0, sblk} + {1'b0, cnt >> brs_pkg::BLK_SHIFT};
                if (cnt == 0)
                    code = brs_pkg::ST_EMPTY;
                else if ((cnt[brs_pkg::BLK_SHIFT-1:0] | offs[brs_pkg::BLK_SHIFT-1:0]) != 0)
                    code = brs_pkg::ST_UNALIGNED;
                else if (end_blk > {1'b0, capacity})
                    code = brs_pkg::ST_BAD_BLOCK;
                else
                    code = brs_pkg::ST_STARTED;
                if (code == brs_pkg::ST_STARTED)
                begin
                    masked     = {21'b0, offs} & (page_bytes - 33'd1);
                    bytes_left = cnt;
                    page_pos   = masked[11:0];
                    next_blk   = sblk;
                    slot_blk   = sblk;
                    slot_segs  = '0;
                    dir_write  = wr;
                    busy       = 1'b1;
                end
                due_results.push_back(status_word(code));
            end
            else if (!busy)
            begin
                due_results.push_back(status_word(brs_pkg::ST_NO_XFER));
            end
            else
            begin
                // One segment up to the page end or the end of the transfer.
                room = page_bytes - {21'b0, page_pos};
                take = (room < {1'b0, bytes_left}) ? room : {1'b0, bytes_left};
                blocks = take[31:0] >> brs_pkg::BLK_SHIFT;
                if (blocks > 512)
                    blocks = 32'd512;
                wide = ({44'b0, page} << PAGE_SHIFT) | {52'b0, page_pos} | {32'b0, blocks};
                bytes_left = bytes_left - (blocks << brs_pkg::BLK_SHIFT);
                next_blk   = next_blk + blocks;
                page_pos   = '0;
                slot_segs  = slot_segs + 4'd1;
                close      = (slot_segs >= SEGMENTS_PER_SLOT) || (bytes_left == 0);

                r              = '0;
                r.kind         = brs_pkg::KIND_SEGMENT;
                r.segment_word = wide[31:0];
                r.last         = !close;
                due_results.push_back(r);

                if (close)
                begin
                    r               = '0;
                    r.kind          = brs_pkg::KIND_SLOT;
                    r.sector        = slot_blk;
                    r.segment_count = slot_segs;
                    r.write_op      = dir_write;
                    r.device        = device_no;
                    r.last          = 1'b1;
                    due_results.push_back(r);
                    slot_blk  = next_blk;
                    slot_segs = '0;
                    if (bytes_left == 0)
                        busy = 1'b0;
                end
            end
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        // Compares one output word with the oldest expectation.
        task match_result(brs_pkg::result_t got);
            brs_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result of kind %0d with nothing expected", got.kind));
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("segment_word", got.segment_word, want.segment_word);
            compare_field("sector", got.sector, want.sector);
            compare_field("segment_count", 32'(got.segment_count), 32'(want.segment_count));
            compare_field("write_op", 32'(got.write_op), 32'(want.write_op));
            compare_field("device", 32'(got.device), 32'(want.device));
            compare_field("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        operation    = 1'b0;
    logic [31:0] start_block  = '0;
    logic [31:0] byte_count   = '0;
    logic [11:0] byte_offset  = '0;
    logic        write_flag   = 1'b0;
    logic [19:0] machine_page = '0;
    logic        out_stall    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [31:0] cfg_data     = '0;
    logic        hold_active  = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] segment_word;
    logic [31:0] sector;
    logic [3:0]  segment_count;
    logic        write_op;
    logic [15:0] device;
    logic        last;
    logic        cfg_ready;

    descriptor_tracker tracker;
    brs_pkg::result_t  seen_word;
    int unsigned       words_sent = 0;
    int unsigned       send_pct   = 0;
    int unsigned       recv_pct   = 0;
    int                phase;

    block_request_segmenter_unit #(
        .PAGE_SHIFT        (PAGE_SHIFT),
        .SEGMENTS_PER_SLOT (SEGMENTS_PER_SLOT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .start_block   (start_block),
        .byte_count    (byte_count),
        .byte_offset   (byte_offset),
        .write_flag    (write_flag),
        .machine_page  (machine_page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .status        (status),
        .segment_word  (segment_word),
        .sector        (sector),
        .segment_count (segment_count),
        .write_op      (write_op),
        .device        (device),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: random stall or a long hold-off, and checking of every word taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_word.kind          = kind;
            seen_word.status        = status;
            seen_word.segment_word  = segment_word;
            seen_word.sector        = sector;
            seen_word.segment_count = segment_count;
            seen_word.write_op      = write_op;
            seen_word.device        = device;
            seen_word.last          = last;
            tracker.match_result(seen_word);
        end
        out_stall <= hold_active || ($urandom_range(0, 99) < recv_pct);
    end

    // Long hold-off on the output while the sender keeps offering words.
    initial
    begin
        wait (words_sent >= 150);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("tb NOT OK");
        $finish;
    end

    // Offers one input word after a random gap and waits until it is taken.
    task send_word(input logic op, input logic [31:0] sblk, input logic [31:0] cnt,
                   input logic [11:0] offs, input logic wr, input logic [19:0] page);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        start_block  <= sblk;
        byte_count   <= cnt;
        byte_offset  <= offs;
        write_flag   <= wr;
        machine_page <= page;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_word(op, sblk, cnt, offs, wr, page);
        words_sent++;
    endtask

    task send_start(input logic [31:0] sblk, input logic [31:0] cnt,
                    input logic [11:0] offs, input logic wr);
        send_word(brs_pkg::OP_START, sblk, cnt, offs, wr, 20'($urandom));
    endtask

    // Unused start fields still carry random values.
    task send_page(input logic [19:0] page);
        send_word(brs_pkg::OP_PAGE, $urandom, $urandom, 12'($urandom),
                  1'($urandom_range(0, 1)), page);
    endtask

    task write_reg(input logic idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_register(idx, data);
        @(posedge clk);
    endtask

    // Stops offering and waits until every expected word has come out.
    task drain;
        in_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A transfer with random content, well-formed when the capacity allows, optionally cut short.
    task run_transfer(input bit cut_short);
        int unsigned blocks;
        int unsigned pages_left;
        logic [31:0] first;
        blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        if (tracker.capacity >= blocks)
            first = $urandom_range(tracker.capacity - blocks, 0);
        else
            first = $urandom;
        send_start(first, blocks << brs_pkg::BLK_SHIFT,
                   12'($urandom_range(0, 7) << brs_pkg::BLK_SHIFT),
                   1'($urandom_range(0, 1)));
        pages_left = cut_short ? $urandom_range(0, 3) : 32'hFFFF_FFFF;
        while (tracker.busy && pages_left != 0)
        begin
            send_page(20'($urandom_range(0, 20'hFFFFF)));
            pages_left--;
        end
    endtask

    task random_sequence;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            run_transfer(pick < 8);
        else if (pick < 80)
            send_start($urandom, $urandom, 12'($urandom_range(0, 4095)),
                       1'($urandom_range(0, 1)));
        else if (pick < 90)
            send_page(20'($urandom_range(0, 20'hFFFFF)));
        else
            send_start($urandom, $urandom & 32'hFFFF_FE00,
                       12'($urandom_range(0, 7) << brs_pkg::BLK_SHIFT),
                       1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at reset: nothing fits on a disk of no blocks.
        send_page(20'h00000);
        send_start(32'd0, 32'd512, 12'd0, 1'b0);
        drain();

        write_reg(brs_pkg::REG_CAPACITY, 32'd1000);
        write_reg(brs_pkg::REG_DEVICE, 32'h0000_FFFF);
        send_start(32'd5, 32'd0, 12'd0, 1'b1);
        send_start(32'd5, 32'd100, 12'd0, 1'b0);
        send_start(32'd5, 32'd512, 12'd100, 1'b0);
        send_start(32'd990, 32'd20 * 512, 12'd0, 1'b0);
        // A transfer that ends exactly at the capacity, one full page.
        send_start(32'd992, 32'd8 * 512, 12'd0, 1'b1);
        send_page(20'hFFFFF);
        // Offset into the first page, spilling over into a second slot.
        send_start(32'd0, 32'd96 * 512, 12'hE00, 1'b0);
        while (tracker.busy)
            send_page(20'($urandom_range(0, 20'hFFFFF)));
        // A new start abandons the open transfer and its slot.
        send_start(32'd100, 32'd64 * 512, 12'd0, 1'b1);
        send_page(20'd12345);
        send_start(32'd0, 32'd0, 12'd0, 1'b0);
        send_page(20'd1);
        drain();

        // Block numbers at the top of the 32-bit range.
        write_reg(brs_pkg::REG_CAPACITY, 32'hFFFF_FFFF);
        write_reg(brs_pkg::REG_DEVICE, 32'd0);
        send_start(32'hFFFF_FFFF, 32'd1024, 12'd0, 1'b0);
        send_start(32'hFFFF_FFFD, 32'd1024, 12'd0, 1'b1);
        send_page(20'd0);

        // Random phases, each with its own settings and idling pattern.
        for (phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(brs_pkg::REG_CAPACITY, $urandom | 32'h0001_0000);
                    write_reg(brs_pkg::REG_DEVICE, $urandom_range(0, 65535));
                    send_pct = 23;
                    recv_pct = 53;
                end
                1:
                begin
                    write_reg(brs_pkg::REG_CAPACITY, $urandom_range(64, 2000));
                    write_reg(brs_pkg::REG_DEVICE, 32'h0000_FFFF);
                    send_pct = 53;
                    recv_pct = 23;
                end
                default:
                begin
                    write_reg(brs_pkg::REG_CAPACITY, 32'hFFFF_FFFF);
                    write_reg(brs_pkg::REG_DEVICE, 32'd0);
                    send_pct = 0;
                    recv_pct = 0;
                end
            endcase
            while (words_sent < 30 + (phase + 1) * ITEM_TARGET / 3)
                random_sequence();
        end

        drain();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
